>>> src/avcc_pkg.sv
package avcc_pkg;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_VER      = 4'd1,
    PH_PROF     = 4'd2,
    PH_COMPAT   = 4'd3,
    PH_LEVEL    = 4'd4,
    PH_LENSIZE  = 4'd5,
    PH_SPSCOUNT = 4'd6,
    PH_SPS_HI   = 4'd7,
    PH_SPS_LO   = 4'd8,
    PH_SPS_DATA = 4'd9,
    PH_PPSCOUNT = 4'd10,
    PH_PPS_HI   = 4'd11,
    PH_PPS_LO   = 4'd12,
    PH_PPS_DATA = 4'd13,
    PH_SKIP     = 4'd14
  } phase_t;

  // result kinds
  localparam logic [2:0] KIND_STARTED = 3'd0;
  localparam logic [2:0] KIND_HEADER  = 3'd1;
  localparam logic [2:0] KIND_SETLEN  = 3'd2;
  localparam logic [2:0] KIND_SPS     = 3'd3;
  localparam logic [2:0] KIND_PPS     = 3'd4;
  localparam logic [2:0] KIND_SKIPPED = 3'd5;
  localparam logic [2:0] KIND_OUTSIDE = 3'd6;

  // header fields
  localparam logic [2:0] HF_VERSION   = 3'd0;
  localparam logic [2:0] HF_PROFILE   = 3'd1;
  localparam logic [2:0] HF_COMPAT    = 3'd2;
  localparam logic [2:0] HF_LEVEL     = 3'd3;
  localparam logic [2:0] HF_LEN_SIZE  = 3'd4;
  localparam logic [2:0] HF_SPS_COUNT = 3'd5;
  localparam logic [2:0] HF_PPS_COUNT = 3'd6;

  // error codes
  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_LEN   = 2'd1;
  localparam logic [1:0] ERR_EARLY = 2'd2;

  localparam logic [7:0] LEN_SIZE_MASK = 8'h03;
  localparam logic [7:0] COUNT_MASK    = 8'h1F;

  typedef struct packed {
    logic        mode;
    logic [31:0] payload_length;
    logic [7:0]  data_byte;
  } avcc_item_t;

  typedef struct packed {
    phase_t      phase;
    logic [31:0] bytes_left;
    logic [7:0]  sets_left;
    logic [7:0]  current_set;
    logic [15:0] current_length;
    logic [15:0] data_count;
    logic [7:0]  length_high_byte;
  } avcc_state_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [2:0]  header_field;
    logic [7:0]  value;
    logic [7:0]  set_index;
    logic [15:0] byte_offset;
    logic [15:0] set_length;
    logic        last_of_set;
    logic [1:0]  error_code;
  } avcc_result_t;

endpackage

>>> src/avcc_if.sv
interface avcc_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [31:0] payload_length;
  logic [7:0]  data_byte;

  modport source (output valid, mode, payload_length, data_byte, input ready);
  modport sink (input valid, mode, payload_length, data_byte, output ready);
endinterface

interface avcc_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [2:0]  header_field;
  logic [7:0]  value;
  logic [7:0]  set_index;
  logic [15:0] byte_offset;
  logic [15:0] set_length;
  logic        last_of_set;
  logic [1:0]  error_code;

  modport source (output valid, kind, header_field, value, set_index, byte_offset,
                  set_length, last_of_set, error_code, input ready);
  modport sink (input valid, kind, header_field, value, set_index, byte_offset,
                set_length, last_of_set, error_code, output ready);
endinterface

>>> src/avcc_in_stage.sv
module avcc_in_stage
  import avcc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  avcc_in_if.sink    in_ch,
  input  logic       advance,
  output logic       item_valid,
  output avcc_item_t item
);

  // no beat is taken while reset is held
  assign in_ch.ready = !rst && (!item_valid || advance);

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ch.ready) begin
      item_valid <= in_ch.valid;
    end
    if (in_ch.valid && in_ch.ready) begin
      item.mode           <= in_ch.mode;
      item.payload_length <= in_ch.payload_length;
      item.data_byte      <= in_ch.data_byte;
    end
  end

endmodule

>>> src/avcc_step.sv
module avcc_step
  import avcc_pkg::*;
(
  input  avcc_state_t  cur,
  input  avcc_item_t   item,
  output avcc_state_t  nxt,
  output avcc_result_t res
);

  logic [31:0] bl;
  logic [15:0] len_new;
  logic [15:0] dc_inc;
  logic [7:0]  sets_dec;
  logic [7:0]  count;
  logic        is_sps;
  logic        active;
  phase_t      np;
  phase_t      fin_phase;

  always_comb begin
    nxt      = cur;
    res      = '0;
    np       = cur.phase;
    active   = 1'b0;
    bl       = cur.bytes_left - 32'd1;
    len_new  = {cur.length_high_byte, item.data_byte};
    dc_inc   = cur.data_count + 16'd1;
    sets_dec = cur.sets_left - 8'd1;
    count    = item.data_byte & COUNT_MASK;
    is_sps   = (cur.phase == PH_SPS_HI) || (cur.phase == PH_SPS_LO) ||
               (cur.phase == PH_SPS_DATA);
    // phase after a finished set
    if (sets_dec == 8'd0) begin
      fin_phase = is_sps ? PH_PPSCOUNT : PH_SKIP;
    end else begin
      fin_phase = is_sps ? PH_SPS_HI : PH_PPS_HI;
    end

    if (!item.mode) begin
      nxt.phase            = PH_IDLE;
      nxt.bytes_left       = item.payload_length;
      nxt.sets_left        = 8'd0;
      nxt.current_set      = 8'd0;
      nxt.current_length   = 16'd0;
      nxt.data_count       = 16'd0;
      nxt.length_high_byte = 8'd0;
      res.kind             = KIND_STARTED;
      if (item.payload_length == 32'd0) begin
        res.error_code = ERR_EARLY;
      end else begin
        nxt.phase = PH_VER;
      end
    end else begin
      active = 1'b1;
      unique case (cur.phase)
        PH_VER: begin
          res.kind = KIND_HEADER; res.header_field = HF_VERSION;
          res.value = item.data_byte; np = PH_PROF;
        end
        PH_PROF: begin
          res.kind = KIND_HEADER; res.header_field = HF_PROFILE;
          res.value = item.data_byte; np = PH_COMPAT;
        end
        PH_COMPAT: begin
          res.kind = KIND_HEADER; res.header_field = HF_COMPAT;
          res.value = item.data_byte; np = PH_LEVEL;
        end
        PH_LEVEL: begin
          res.kind = KIND_HEADER; res.header_field = HF_LEVEL;
          res.value = item.data_byte; np = PH_LENSIZE;
        end
        PH_LENSIZE: begin
          res.kind = KIND_HEADER; res.header_field = HF_LEN_SIZE;
          res.value = (item.data_byte & LEN_SIZE_MASK) + 8'd1;
          np = PH_SPSCOUNT;
        end
        PH_SPSCOUNT: begin
          res.kind = KIND_HEADER; res.header_field = HF_SPS_COUNT;
          res.value = count;
          nxt.sets_left = count;
          nxt.current_set = 8'd0;
          np = (count == 8'd0) ? PH_PPSCOUNT : PH_SPS_HI;
        end
        PH_PPSCOUNT: begin
          res.kind = KIND_HEADER; res.header_field = HF_PPS_COUNT;
          res.value = item.data_byte;
          nxt.sets_left = item.data_byte;
          nxt.current_set = 8'd0;
          np = (item.data_byte == 8'd0) ? PH_SKIP : PH_PPS_HI;
        end
        PH_SPS_HI, PH_PPS_HI: begin
          res.kind = KIND_SETLEN;
          res.header_field = is_sps ? HF_SPS_COUNT : HF_PPS_COUNT;
          res.value = item.data_byte;
          res.set_index = cur.current_set;
          nxt.length_high_byte = item.data_byte;
          np = is_sps ? PH_SPS_LO : PH_PPS_LO;
        end
        PH_SPS_LO, PH_PPS_LO: begin
          res.kind = KIND_SETLEN;
          res.header_field = is_sps ? HF_SPS_COUNT : HF_PPS_COUNT;
          res.value = item.data_byte;
          res.set_index = cur.current_set;
          res.set_length = len_new;
          nxt.current_length = len_new;
          nxt.data_count = 16'd0;
          if ({16'd0, len_new} > bl) begin
            res.error_code = ERR_LEN;
            np = PH_SKIP;
          end else if (len_new == 16'd0) begin
            nxt.current_set = cur.current_set + 8'd1;
            nxt.sets_left = sets_dec;
            np = fin_phase;
          end else begin
            np = is_sps ? PH_SPS_DATA : PH_PPS_DATA;
          end
        end
        PH_SPS_DATA, PH_PPS_DATA: begin
          res.kind = is_sps ? KIND_SPS : KIND_PPS;
          res.value = item.data_byte;
          res.set_index = cur.current_set;
          res.byte_offset = cur.data_count;
          res.set_length = cur.current_length;
          nxt.data_count = dc_inc;
          if (dc_inc >= cur.current_length) begin
            res.last_of_set = 1'b1;
            nxt.current_set = cur.current_set + 8'd1;
            nxt.sets_left = sets_dec;
            np = fin_phase;
          end
        end
        PH_SKIP: begin
          res.kind = KIND_SKIPPED;
          res.value = item.data_byte;
        end
        default: begin
          // no box open
          active = 1'b0;
          res.kind = KIND_OUTSIDE;
        end
      endcase

      if (active) begin
        nxt.bytes_left = bl;
        if (bl == 32'd0) begin
          if (np != PH_SKIP && res.error_code == ERR_NONE) begin
            res.error_code = ERR_EARLY;
          end
          np = PH_IDLE;
        end
        nxt.phase = np;
      end else begin
        nxt.phase = PH_IDLE;
      end
    end
  end

endmodule

>>> src/avc_decoder_config_record_parser.sv
// avcC box payload parser, one byte per beat.
// in_ch: a beat with mode 0 opens a box and gives its payload length; a beat
// with mode 1 carries the next payload byte. out_ch: exactly one result beat
// per input beat, in order, tagging the byte with its role (header field, set
// length byte, sps or pps data byte, skipped, outside box, box start), set index, offset
// within its set, declared set length, last-of-set and an error code.
// Path: an accepted beat is registered in the input register, decoded against
// the parser state by combinational logic, and its result is registered in the
// result register, which drives out_ch.
// Throughput: one beat per cycle while out_ch does not stall; the phase and
// counter update of one byte is combinational logic between the input and result registers.
// Reset (synchronous, rst high) returns to idle with no box open and empties
// both registers; in_ch.ready stays low while rst is high and the first beat
// can be taken in the cycle after reset.
// When out_ch stalls, the result register holds its beat, the input register
// still takes one more beat, and in_ch.ready drops only once both are full.
module avc_decoder_config_record_parser
  import avcc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  avcc_in_if.sink     in_ch,
  avcc_out_if.source  out_ch
);

  logic         item_valid;
  avcc_item_t   item;
  logic         advance;
  avcc_state_t  state;
  avcc_state_t  state_next;
  avcc_result_t result_next;
  avcc_result_t result;
  logic         out_valid;

  assign advance = !out_valid || out_ch.ready;

  avcc_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_ch),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  avcc_step u_step (
    .cur  (state),
    .item (item),
    .nxt  (state_next),
    .res  (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      state     <= '{phase: PH_IDLE, default: '0};
    end else if (advance) begin
      out_valid <= item_valid;
      if (item_valid) begin
        state <= state_next;
      end
    end
    if (advance && item_valid) begin
      result <= result_next;
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.kind         = result.kind;
  assign out_ch.header_field = result.header_field;
  assign out_ch.value        = result.value;
  assign out_ch.set_index    = result.set_index;
  assign out_ch.byte_offset  = result.byte_offset;
  assign out_ch.set_length   = result.set_length;
  assign out_ch.last_of_set  = result.last_of_set;
  assign out_ch.error_code   = result.error_code;

endmodule

>>> src/avcc_checker.sv
module avcc_checker
  import avcc_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  kind,
  input logic [2:0]  header_field,
  input logic [7:0]  value,
  input logic [7:0]  set_index,
  input logic [15:0] byte_offset,
  input logic [15:0] set_length,
  input logic        last_of_set,
  input logic [1:0]  error_code
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(value) &&
      $stable(set_index) && $stable(byte_offset) && $stable(error_code))
    else $error("result beat changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst && $past(rst) |-> !out_valid)
    else $error("result beat right after reset");

  a_outside_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_OUTSIDE |-> header_field == 3'd0 && value == 8'd0 &&
      set_index == 8'd0 && byte_offset == 16'd0 && set_length == 16'd0 &&
      !last_of_set && error_code == ERR_NONE)
    else $error("outside-box beat carries fields");

  // the last data byte sits at the end of its declared length
  a_last_at_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_of_set |-> (kind == KIND_SPS || kind == KIND_PPS) &&
      byte_offset == set_length - 16'd1)
    else $error("last_of_set off the end of its set");

  a_len_err_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid && error_code == ERR_LEN |-> kind == KIND_SETLEN)
    else $error("length error on a non length beat");

endmodule

bind avc_decoder_config_record_parser avcc_checker u_avcc_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .kind         (out_ch.kind),
  .header_field (out_ch.header_field),
  .value        (out_ch.value),
  .set_index    (out_ch.set_index),
  .byte_offset  (out_ch.byte_offset),
  .set_length   (out_ch.set_length),
  .last_of_set  (out_ch.last_of_set),
  .error_code   (out_ch.error_code)
);

>>> test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import avcc_pkg::*;

  localparam int IDLE_LIMIT = 1000;
  localparam int HOLD_CYCLES = 80;

  class avcc_tag_checker;
    avcc_result_t tags_due[$];
    phase_t       step;
    logic [31:0]  remaining;
    logic [7:0]   sets_to_go;
    logic [7:0]   set_no;
    logic [7:0]   len_msb;
    logic [15:0]  set_len;
    logic [15:0]  offset;
    int           fails;
    int           beats;
    int           outside;
    int           boxes;
    int           results;
    int           len_errors;
    int           early_ends;

    function new();
      clear_state();
    endfunction

    function void clear_state();
      step = PH_IDLE;
      remaining = '0;
      sets_to_go = '0;
      set_no = '0;
      len_msb = '0;
      set_len = '0;
      offset = '0;
    endfunction

    function phase_t open_sets(logic [7:0] count, logic is_sps);
      sets_to_go = count;
      set_no = '0;
      if (count == 8'd0) begin
        if (is_sps) return PH_PPSCOUNT;
        return PH_SKIP;
      end
      if (is_sps) return PH_SPS_HI;
      return PH_PPS_HI;
    endfunction

    function phase_t close_set(logic is_sps);
      set_no = set_no + 8'd1;
      sets_to_go = sets_to_go - 8'd1;
      if (sets_to_go == 8'd0) begin
        if (is_sps) return PH_PPSCOUNT;
        return PH_SKIP;
      end
      if (is_sps) return PH_SPS_HI;
      return PH_PPS_HI;
    endfunction

    function void take_beat(avcc_item_t it);
      avcc_result_t r;
      phase_t       nxt;
      logic         is_sps;
      logic [7:0]   b;
      r = '0;
      b = it.data_byte;
      beats++;
      if (it.mode == 1'b0) begin
        clear_state();
        boxes++;
        remaining = it.payload_length;
        r.kind = KIND_STARTED;
        if (remaining == 32'd0) r.error_code = ERR_EARLY;
        else step = PH_VER;
      end else if (step == PH_IDLE) begin
        outside++;
        r.kind = KIND_OUTSIDE;
      end else begin
        remaining = remaining - 32'd1;
        nxt = step;
        case (step)
          PH_VER, PH_PROF, PH_COMPAT, PH_LEVEL: begin
            r.kind = KIND_HEADER;
            r.header_field = 3'(step - PH_VER);
            r.value = b;
            nxt = phase_t'(step + 1);
          end
          PH_LENSIZE: begin
            r.kind = KIND_HEADER;
            r.header_field = HF_LEN_SIZE;
            r.value = (b & LEN_SIZE_MASK) + 8'd1;
            nxt = PH_SPSCOUNT;
          end
          PH_SPSCOUNT: begin
            r.kind = KIND_HEADER;
            r.header_field = HF_SPS_COUNT;
            r.value = b & COUNT_MASK;
            nxt = open_sets(b & COUNT_MASK, 1'b1);
          end
          PH_PPSCOUNT: begin
            r.kind = KIND_HEADER;
            r.header_field = HF_PPS_COUNT;
            r.value = b;
            nxt = open_sets(b, 1'b0);
          end
          PH_SPS_HI, PH_PPS_HI: begin
            is_sps = (step == PH_SPS_HI);
            r.kind = KIND_SETLEN;
            r.header_field = is_sps ? HF_SPS_COUNT : HF_PPS_COUNT;
            r.value = b;
            r.set_index = set_no;
            len_msb = b;
            nxt = phase_t'(step + 1);
          end
          PH_SPS_LO, PH_PPS_LO: begin
            is_sps = (step == PH_SPS_LO);
            set_len = {len_msb, b};
            offset = '0;
            r.kind = KIND_SETLEN;
            r.header_field = is_sps ? HF_SPS_COUNT : HF_PPS_COUNT;
            r.value = b;
            r.set_index = set_no;
            r.set_length = set_len;
            // declared length checked against what is left after this byte
            if ({16'd0, set_len} > remaining) begin
              r.error_code = ERR_LEN;
              nxt = PH_SKIP;
            end else if (set_len == 16'd0) begin
              nxt = close_set(is_sps);
            end else begin
              nxt = phase_t'(step + 1);
            end
          end
          PH_SPS_DATA, PH_PPS_DATA: begin
            is_sps = (step == PH_SPS_DATA);
            r.kind = is_sps ? KIND_SPS : KIND_PPS;
            r.value = b;
            r.set_index = set_no;
            r.byte_offset = offset;
            r.set_length = set_len;
            offset = offset + 16'd1;
            if (offset >= set_len) begin
              r.last_of_set = 1'b1;
              nxt = close_set(is_sps);
            end
          end
          default: begin
            r.kind = KIND_SKIPPED;
            r.value = b;
            nxt = PH_SKIP;
          end
        endcase
        if (remaining == 32'd0) begin
          if (nxt != PH_SKIP && r.error_code == ERR_NONE) r.error_code = ERR_EARLY;
          nxt = PH_IDLE;
        end
        step = nxt;
      end
      tags_due.insert(tags_due.size(), r);
    endfunction

    function void compare(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        fails++;
      end
    endfunction

    function void check_tag(avcc_result_t got);
      avcc_result_t want;
      if (tags_due.size() == 0) begin
        $error("result beat with nothing expected: kind %0d value %0d", got.kind, got.value);
        fails++;
        return;
      end
      want = tags_due.pop_front();
      results++;
      if (want.error_code == ERR_LEN) len_errors++;
      if (want.error_code == ERR_EARLY) early_ends++;
      compare("kind", want.kind, got.kind);
      compare("header_field", want.header_field, got.header_field);
      compare("value", want.value, got.value);
      compare("set_index", want.set_index, got.set_index);
      compare("byte_offset", want.byte_offset, got.byte_offset);
      compare("set_length", want.set_length, got.set_length);
      compare("last_of_set", want.last_of_set, got.last_of_set);
      compare("error_code", want.error_code, got.error_code);
    endfunction

    function int pending();
      return tags_due.size();
    endfunction
  endclass

  logic clk;
  logic rst;

  avcc_in_if  in_ch();
  avcc_out_if out_ch();

  avc_decoder_config_record_parser u_top (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  avcc_tag_checker chk = new();

  int  hold_left;
  int  stall_left;
  int  run_left;
  bit  held;
  bit  calm;
  int  idle_cycles;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.mode = 1'b0;
    in_ch.payload_length = '0;
    in_ch.data_byte = '0;
    out_ch.ready = 1'b0;
    hold_left = 0;
    stall_left = 0;
    run_left = 0;
    held = 1'b0;
    calm = 1'b0;
    idle_cycles = 0;
  end

  function automatic int pick_gap();
    int r;
    if (calm || hold_left > 0) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic int pick_set_len();
    case ($urandom_range(0, 19))
      0:       return 0;
      1:       return $urandom_range(200, 300);
      default: return $urandom_range(1, 6);
    endcase
  endfunction

  function automatic void add_sets(ref logic [7:0] rec[$], input int count);
    int slen;
    repeat (count) begin
      slen = pick_set_len();
      rec.insert(rec.size(), 8'(slen >> 8));
      rec.insert(rec.size(), 8'(slen));
      repeat (slen) rec.insert(rec.size(), 8'($urandom));
    end
  endfunction

  // valid stays high across back-to-back beats
  task automatic send_beat(input logic mode, input logic [31:0] plen, input logic [7:0] b);
    int         gap;
    avcc_item_t it;
    it.mode = mode;
    it.payload_length = plen;
    it.data_byte = b;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.mode <= mode;
    in_ch.payload_length <= plen;
    in_ch.data_byte <= b;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    chk.take_beat(it);
  endtask

  task automatic send_random_box();
    logic [7:0]  rec[$];
    logic [31:0] plen;
    int          n_sps;
    int          n_pps;
    int          k;
    repeat (5) rec.insert(rec.size(), 8'($urandom));
    n_sps = ($urandom_range(0, 15) == 0) ? $urandom_range(4, 31) : $urandom_range(0, 3);
    rec.insert(rec.size(), {3'($urandom), 5'(n_sps)});
    add_sets(rec, n_sps);
    n_pps = ($urandom_range(0, 15) == 0) ? $urandom_range(4, 20) : $urandom_range(0, 3);
    rec.insert(rec.size(), 8'(n_pps));
    add_sets(rec, n_pps);
    // some boxes are cut short, most carry a little trailing padding
    if ($urandom_range(0, 9) < 2) plen = $urandom_range(1, rec.size());
    else plen = rec.size() + $urandom_range(0, 3);
    while (rec.size() < plen) rec.insert(rec.size(), 8'($urandom));
    send_beat(1'b0, plen, 8'($urandom));
    for (k = 0; k < plen; k++) send_beat(1'b1, $urandom, rec[k]);
  endtask

  task automatic send_noise_box();
    logic [31:0] plen;
    int          n;
    plen = $urandom_range(0, 1) ? $urandom : $urandom_range(1, 12);
    n = (plen < 30) ? int'(plen) : $urandom_range(1, 30);
    send_beat(1'b0, plen, 8'($urandom));
    repeat (n) send_beat(1'b1, $urandom, 8'($urandom));
  endtask

  // receiver: short stalls, occasional long ones, calm runs, one long hold-off
  always @(negedge clk) begin
    if (!held && chk.beats >= 250) begin
      held = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left--;
    end else if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left--;
    end else begin
      out_ch.ready <= 1'b1;
      if (run_left > 0) begin
        run_left--;
      end else begin
        run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150) : $urandom_range(0, 8);
        stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
                                                  : $urandom_range(1, 3);
      end
    end
  end

  always @(posedge clk) begin
    avcc_result_t got;
    if (!rst && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got.kind = out_ch.kind;
      got.header_field = out_ch.header_field;
      got.value = out_ch.value;
      got.set_index = out_ch.set_index;
      got.byte_offset = out_ch.byte_offset;
      got.set_length = out_ch.set_length;
      got.last_of_set = out_ch.last_of_set;
      got.error_code = out_ch.error_code;
      chk.check_tag(got);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("avc_decoder_config_record_parser verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst = 1'b1;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // zero-length start, then an open box abandoned by a new start
    send_beat(1'b0, 32'd0, 8'h00);
    send_beat(1'b0, 32'hFFFF_FFFF, 8'hFF);
    send_beat(1'b1, 32'd0, 8'h00);
    // full record: masked length size and sps count, one empty pps set, one padding byte
    send_beat(1'b0, 32'd14, 8'h00);
    send_beat(1'b1, 32'd0, 8'h01);
    send_beat(1'b1, 32'd0, 8'h64);
    send_beat(1'b1, 32'd0, 8'h00);
    send_beat(1'b1, 32'd0, 8'h1F);
    send_beat(1'b1, 32'd0, 8'hFF);
    send_beat(1'b1, 32'd0, 8'hE1);
    send_beat(1'b1, 32'd0, 8'h00);
    send_beat(1'b1, 32'd0, 8'h02);
    send_beat(1'b1, 32'd0, 8'h67);
    send_beat(1'b1, 32'd0, 8'h42);
    send_beat(1'b1, 32'd0, 8'h01);
    send_beat(1'b1, 32'd0, 8'h00);
    send_beat(1'b1, 32'd0, 8'h00);
    send_beat(1'b1, 32'd0, 8'h80);
    // no sps, pps length runs past the payload
    send_beat(1'b0, 32'd9, 8'h00);
    send_beat(1'b1, 32'd0, 8'h01);
    send_beat(1'b1, 32'd0, 8'h4D);
    send_beat(1'b1, 32'd0, 8'h40);
    send_beat(1'b1, 32'd0, 8'h0A);
    send_beat(1'b1, 32'd0, 8'hFC);
    send_beat(1'b1, 32'd0, 8'h00);
    send_beat(1'b1, 32'd0, 8'h01);
    send_beat(1'b1, 32'd0, 8'h00);
    send_beat(1'b1, 32'd0, 8'h05);
    send_beat(1'b1, 32'd0, 8'hAA);

    while (chk.beats - chk.outside < 500) begin
      calm = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 9) == 0) begin
        send_noise_box();
      end else begin
        send_random_box();
        if ($urandom_range(0, 7) == 0)
          repeat ($urandom_range(1, 2)) send_beat(1'b1, $urandom, 8'($urandom));
      end
    end
    calm = 1'b0;

    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (chk.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("covered %0d input beats in %0d boxes, %0d outside a box; %0d results checked",
             chk.beats, chk.boxes, chk.outside, chk.results);
    $display("set length errors %0d, early payload ends %0d", chk.len_errors, chk.early_ends);
    if (chk.fails == 0 && chk.pending() == 0) begin
      $display("avc_decoder_config_record_parser verification clean");
    end else begin
      $display("avc_decoder_config_record_parser verification failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/avcc_pkg.sv
src/avcc_if.sv
src/avcc_in_stage.sv
src/avcc_step.sv
src/avc_decoder_config_record_parser.sv
src/avcc_checker.sv
test/tb_top.sv
